### src/cartridge_bank_mapper_irq_assert.svh
// Assertion macros for the bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH

`ifndef SYNTHESIS
`define CBMI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CBMI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CBMI_ASSERT(lbl, prop, msg)
`define CBMI_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### src/cbm_pkg.sv
package cbm_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned MappedW = 21;
  localparam int unsigned NprgW   = 9;
  localparam int unsigned NumBanks = 8;

  localparam logic [NprgW-1:0] NprgReset = 9'd2;

  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_PRG_FETCH = 2'd1,
    OP_CHR_FETCH = 2'd2,
    OP_NT_ACCESS = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    GRP_BANK      = 2'd0,
    GRP_MIRROR    = 2'd1,
    GRP_IRQ_LATCH = 2'd2,
    GRP_IRQ_EN    = 2'd3
  } reg_group_e;

  typedef struct packed {
    logic [NumBanks-1:0][DataW-1:0] banks;
    logic [DataW-1:0]               sel;
    logic                           hmirror;
    logic [NprgW-1:0]               nprg;
  } bank_state_t;

  typedef struct packed {
    logic             set_reload_val;
    logic [DataW-1:0] reload_val;
    logic             req_reload;
    logic             set_enable;
    logic             enable;
  } irq_ctl_t;

  typedef struct packed {
    logic enabled;
    logic count_zero;
  } irq_stat_t;

endpackage

### src/cartridge_bank_mapper_irq.sv
// Channel  Handshake               Payload
// in       in_valid_i / in_stall_o  opcode_i, address_i, write_data_i
// out      out_valid_o / out_stall_i mapped_address_o, irq_pulse_o
// cfg      cfg_we_i                 cfg_wdata_i (num_prg_banks)
//
// One transaction per cycle sustained while out_stall_i is low; a transaction
// passes from the input register to the result register, with the mapping state
// updated as the transaction moves into the result register.
// Reset clears the bank, mirroring and counter state; num_prg_banks resets to 2.
// A stalled result holds the input register, which then stalls the input.
module cartridge_bank_mapper_irq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbm_pkg::NprgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic [cbm_pkg::AddrW-1:0]     address_i,
  input  logic [cbm_pkg::DataW-1:0]     write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cbm_pkg::MappedW-1:0]   mapped_address_o,
  output logic                          irq_pulse_o
);
  import cbm_pkg::*;

  logic                 in_valid_q;
  opcode_e              op_q;
  logic [AddrW-1:0]     addr_q;
  logic [DataW-1:0]     data_q;
  logic                 out_valid_q;
  logic [MappedW-1:0]   mapped_q, mapped_d;
  logic                 irq_q, irq_d;
  logic                 out_free;
  logic                 advance;
  logic                 in_load;
  bank_state_t          bank_state;
  irq_ctl_t             irq_ctl;
  irq_stat_t            irq_stat;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  cbm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_en_i     (advance && (op_q == OP_REG_WRITE)),
    .addr_i      (addr_q),
    .data_i      (data_q),
    .state_o     (bank_state),
    .irq_ctl_o   (irq_ctl)
  );

  cbm_irq u_irq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (irq_ctl),
    .clk_en_i (advance && (op_q == OP_CHR_FETCH)),
    .a12_i    (addr_q[12]),
    .fire_o   (irq_d),
    .stat_o   (irq_stat)
  );

  cbm_map u_map (
    .op_i     (op_q),
    .addr_i   (addr_q),
    .state_i  (bank_state),
    .mapped_o (mapped_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      op_q   <= opcode_e'(opcode_i);
      addr_q <= address_i;
      data_q <= write_data_i;
    end
    if (advance) begin
      mapped_q <= mapped_d;
      irq_q    <= irq_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mapped_address_o = mapped_q;
  assign irq_pulse_o      = irq_q;

  `include "cartridge_bank_mapper_irq_assert.svh"

  `CBMI_ASSERT(a_stall_needs_item, !in_stall_o || in_valid_q, "stall without held item")
  `CBMI_ASSERT_NEXT(a_reg_write_zero, advance && (op_q == OP_REG_WRITE), mapped_q == '0, "reg write result not zero")
  `CBMI_ASSERT(a_irq_state, !(out_valid_q && irq_q) || (irq_stat.enabled && irq_stat.count_zero), "irq without enabled zero count")

endmodule

### src/cbm_regs.sv
module cbm_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbm_pkg::NprgW-1:0]     cfg_wdata_i,
  input  logic                          wr_en_i,
  input  logic [cbm_pkg::AddrW-1:0]     addr_i,
  input  logic [cbm_pkg::DataW-1:0]     data_i,
  output cbm_pkg::bank_state_t          state_o,
  output cbm_pkg::irq_ctl_t             irq_ctl_o
);
  import cbm_pkg::*;

  logic [NumBanks-1:0][DataW-1:0] banks_q, banks_d;
  logic [DataW-1:0]               sel_q, sel_d;
  logic                           hmirror_q, hmirror_d;
  logic [NprgW-1:0]               nprg_q;
  reg_group_e                     grp;
  logic                           odd;

  assign grp = reg_group_e'(addr_i[14:13]);
  assign odd = addr_i[0];

  always_comb begin
    banks_d   = banks_q;
    sel_d     = sel_q;
    hmirror_d = hmirror_q;
    irq_ctl_o = '0;
    irq_ctl_o.reload_val = data_i;
    irq_ctl_o.enable     = odd;
    if (wr_en_i) begin
      unique case (grp)
        GRP_BANK: begin
          if (odd) banks_d[sel_q[2:0]] = data_i;
          else     sel_d = data_i;
        end
        GRP_MIRROR: begin
          if (!odd) hmirror_d = data_i[0];
        end
        GRP_IRQ_LATCH: begin
          if (odd) irq_ctl_o.req_reload = 1'b1;
          else     irq_ctl_o.set_reload_val = 1'b1;
        end
        GRP_IRQ_EN: begin
          irq_ctl_o.set_enable = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banks_q   <= '0;
      sel_q     <= '0;
      hmirror_q <= 1'b0;
      nprg_q    <= NprgReset;
    end else begin
      banks_q   <= banks_d;
      sel_q     <= sel_d;
      hmirror_q <= hmirror_d;
      if (cfg_we_i) nprg_q <= cfg_wdata_i;
    end
  end

  assign state_o.banks   = banks_q;
  assign state_o.sel     = sel_q;
  assign state_o.hmirror = hmirror_q;
  assign state_o.nprg    = nprg_q;

endmodule

### src/cbm_irq.sv
module cbm_irq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbm_pkg::irq_ctl_t  ctl_i,
  input  logic               clk_en_i,
  input  logic               a12_i,
  output logic               fire_o,
  output cbm_pkg::irq_stat_t stat_o
);
  import cbm_pkg::*;

  logic [DataW-1:0] count_q, count_d;
  logic [DataW-1:0] reload_q;
  logic             pending_q, pending_d;
  logic             last_a12_q;
  logic             enabled_q;
  logic             rise;

  assign rise = clk_en_i && a12_i && !last_a12_q;

  always_comb begin
    count_d   = count_q;
    pending_d = pending_q || ctl_i.req_reload;
    if (rise) begin
      if ((count_q == '0) || pending_q) begin
        count_d   = reload_q;
        pending_d = 1'b0;
      end else begin
        count_d = count_q - DataW'(1);
      end
    end
  end

  assign fire_o = rise && (count_d == '0) && enabled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reload_q   <= '0;
      pending_q  <= 1'b0;
      last_a12_q <= 1'b0;
      enabled_q  <= 1'b0;
    end else begin
      count_q   <= count_d;
      pending_q <= pending_d;
      if (ctl_i.set_reload_val) reload_q <= ctl_i.reload_val;
      if (ctl_i.set_enable) enabled_q <= ctl_i.enable;
      if (clk_en_i) last_a12_q <= a12_i;
    end
  end

  assign stat_o.enabled    = enabled_q;
  assign stat_o.count_zero = (count_q == '0);

endmodule

### src/cbm_map.sv
module cbm_map (
  input  cbm_pkg::opcode_e              op_i,
  input  logic [cbm_pkg::AddrW-1:0]     addr_i,
  input  cbm_pkg::bank_state_t          state_i,
  output logic [cbm_pkg::MappedW-1:0]   mapped_o
);
  import cbm_pkg::*;

  logic [DataW-1:0] second_last;
  logic [DataW-1:0] last;
  logic [DataW-1:0] prg_bank;
  logic [DataW-1:0] chr_bank;
  logic [2:0]       chr_slot;
  logic [AddrW-1:0] nt_addr;
  logic             prg_mode;

  assign second_last = state_i.nprg[DataW-1:0] - 8'd2;
  assign last        = state_i.nprg[DataW-1:0] - 8'd1;
  assign prg_mode    = state_i.sel[6];
  assign chr_slot    = addr_i[12:10] ^ {state_i.sel[7], 2'b00};

  always_comb begin
    case (addr_i[14:13])
      2'd0:    prg_bank = prg_mode ? second_last : state_i.banks[6];
      2'd1:    prg_bank = state_i.banks[7];
      2'd2:    prg_bank = prg_mode ? state_i.banks[6] : second_last;
      default: prg_bank = last;
    endcase
  end

  always_comb begin
    case (chr_slot)
      3'd0:    chr_bank = state_i.banks[0] & 8'hFE;
      3'd1:    chr_bank = state_i.banks[0] | 8'h01;
      3'd2:    chr_bank = state_i.banks[1] & 8'hFE;
      3'd3:    chr_bank = state_i.banks[1] | 8'h01;
      default: chr_bank = state_i.banks[chr_slot - 3'd2];
    endcase
  end

  always_comb begin
    nt_addr     = addr_i;
    nt_addr[11] = 1'b0;
    if (state_i.hmirror) nt_addr[10] = addr_i[11];
  end

  always_comb begin
    unique case (op_i)
      OP_REG_WRITE: mapped_o = '0;
      OP_PRG_FETCH: mapped_o = {prg_bank, addr_i[12:0]};
      OP_CHR_FETCH: mapped_o = {3'b000, chr_bank, addr_i[9:0]};
      OP_NT_ACCESS: mapped_o = {5'b00000, nt_addr};
      default:      mapped_o = '0;
    endcase
  end

endmodule

### bench/tb_top.sv
module tb_top;
  import cbm_pkg::*;

  typedef struct packed {
    logic [MappedW-1:0] mapped_address;
    logic               irq_pulse;
  } bus_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [NprgW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  opcode_e            opcode_i = OP_REG_WRITE;
  logic [AddrW-1:0]   address_i = '0;
  logic [DataW-1:0]   write_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [MappedW-1:0] mapped_address_o;
  logic               irq_pulse_o;

  bus_result_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b1;

  logic [DataW-1:0] bank_reg [NumBanks] = '{default: '0};
  logic [DataW-1:0] select_byte = '0;
  logic [DataW-1:0] scan_count = '0;
  logic [DataW-1:0] scan_latch = '0;
  logic             reload_req = 1'b0;
  logic             prev_a12 = 1'b0;
  logic             irq_on = 1'b0;
  logic             hmirror = 1'b0;
  logic [NprgW-1:0] prg_bank_count = NprgReset;

  cartridge_bank_mapper_irq DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mapped_address_o(mapped_address_o),
    .irq_pulse_o     (irq_pulse_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bus_result_t predict_access(opcode_e op, logic [AddrW-1:0] addr,
                                                 logic [DataW-1:0] data);
    bus_result_t res;
    logic [DataW-1:0] bank;
    logic [DataW-1:0] second_last;
    logic [2:0]       slot;
    logic [12:0]      chr_addr;
    res = '0;
    second_last = prg_bank_count[7:0] - 8'd2;
    case (op)
      OP_REG_WRITE: begin
        case (reg_group_e'(addr[14:13]))
          GRP_BANK: begin
            if (!addr[0]) begin
              select_byte = data;
            end else begin
              bank_reg[select_byte[2:0]] = data;
            end
          end
          GRP_MIRROR: begin
            if (!addr[0]) begin
              hmirror = data[0];
            end
          end
          GRP_IRQ_LATCH: begin
            if (!addr[0]) begin
              scan_latch = data;
            end else begin
              reload_req = 1'b1;
            end
          end
          default: begin
            irq_on = addr[0];
          end
        endcase
      end
      OP_PRG_FETCH: begin
        case (addr[14:13])
          2'd0: bank = select_byte[6] ? second_last : bank_reg[6];
          2'd1: bank = bank_reg[7];
          2'd2: bank = select_byte[6] ? bank_reg[6] : second_last;
          default: bank = prg_bank_count[7:0] - 8'd1;
        endcase
        res.mapped_address = {bank, addr[12:0]};
      end
      OP_CHR_FETCH: begin
        chr_addr = addr[12:0];
        if (chr_addr[12] && !prev_a12) begin
          if (scan_count == 8'd0 || reload_req) begin
            scan_count = scan_latch;
            reload_req = 1'b0;
          end else begin
            scan_count = scan_count - 8'd1;
          end
          res.irq_pulse = (scan_count == 8'd0) && irq_on;
        end
        prev_a12 = chr_addr[12];
        slot = chr_addr[12:10] ^ {select_byte[7], 2'b00};
        case (slot)
          3'd0: bank = {bank_reg[0][7:1], 1'b0};
          3'd1: bank = {bank_reg[0][7:1], 1'b1};
          3'd2: bank = {bank_reg[1][7:1], 1'b0};
          3'd3: bank = {bank_reg[1][7:1], 1'b1};
          default: bank = bank_reg[slot - 3'd2];
        endcase
        res.mapped_address = {3'b000, bank, chr_addr[9:0]};
      end
      default: begin
        res.mapped_address = {5'd0, addr[15:12], 1'b0,
                              hmirror ? addr[11] : addr[10], addr[9:0]};
      end
    endcase
    return res;
  endfunction

  task automatic send_access(opcode_e op, logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_access(op, addr, data));
  endtask

  task automatic load_prg_bank_count(logic [NprgW-1:0] count);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    prg_bank_count = count;
  endtask

  task automatic test_power_on_mapping();
    send_access(OP_PRG_FETCH, 16'h0000, 8'h00);
    send_access(OP_PRG_FETCH, 16'hFFFF, 8'hFF);
    send_access(OP_CHR_FETCH, 16'h0000, 8'h00);
    send_access(OP_NT_ACCESS, 16'h0C00, 8'h00);
  endtask

  task automatic test_register_decode();
    send_access(OP_REG_WRITE, 16'h8000, 8'hC7);
    send_access(OP_REG_WRITE, 16'h0001, 8'hFF);
    send_access(OP_REG_WRITE, 16'h0000, 8'h06);
    send_access(OP_REG_WRITE, 16'h0001, 8'h80);
    send_access(OP_PRG_FETCH, 16'h4000, 8'h00);
    send_access(OP_REG_WRITE, 16'h2000, 8'h01);
    send_access(OP_REG_WRITE, 16'h2001, 8'hFF);
    send_access(OP_NT_ACCESS, 16'hFFFF, 8'h00);
  endtask

  task automatic test_scanline_irq();
    send_access(OP_CHR_FETCH, 16'hFFFF, 8'h00);
    send_access(OP_REG_WRITE, 16'h4000, 8'h01);
    send_access(OP_REG_WRITE, 16'h6001, 8'h00);
    send_access(OP_CHR_FETCH, 16'h0000, 8'h00);
    send_access(OP_CHR_FETCH, 16'h1000, 8'h00);
    send_access(OP_CHR_FETCH, 16'h0400, 8'h00);
    send_access(OP_CHR_FETCH, 16'h1C00, 8'h00);
    send_access(OP_REG_WRITE, 16'h4001, 8'h00);
    send_access(OP_CHR_FETCH, 16'h0000, 8'h00);
    send_access(OP_CHR_FETCH, 16'h1000, 8'h00);
    send_access(OP_REG_WRITE, 16'h4000, 8'h00);
    send_access(OP_REG_WRITE, 16'h4001, 8'h00);
    send_access(OP_CHR_FETCH, 16'h0000, 8'h00);
    send_access(OP_CHR_FETCH, 16'h1FFF, 8'h00);
    send_access(OP_REG_WRITE, 16'h6000, 8'h00);
  endtask

  task automatic test_pattern_inversion();
    send_access(OP_REG_WRITE, 16'h0000, 8'h80);
    send_access(OP_REG_WRITE, 16'h0001, 8'hFF);
    send_access(OP_CHR_FETCH, 16'h0C00, 8'h00);
    send_access(OP_CHR_FETCH, 16'h1000, 8'h00);
    send_access(OP_NT_ACCESS, 16'h0000, 8'h00);
    send_access(OP_PRG_FETCH, 16'h7FFF, 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [NprgW-1:0] bank_counts [7];
    opcode_e          op;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    int unsigned      pick;
    bank_counts = '{9'd256, 9'd255, 9'd3, 9'd0, 9'd511, 9'd2, 9'd2};
    bank_counts[5] = NprgW'($urandom_range(2, 256));
    foreach (bank_counts[i]) begin
      load_prg_bank_count(bank_counts[i]);
      if (i == 6) begin
        idle_on = 1'b0;
      end
      repeat (100) begin
        pick = $urandom_range(0, 99);
        addr = AddrW'($urandom);
        data = DataW'($urandom);
        if (pick < 30) begin
          op = OP_REG_WRITE;
        end else if (pick < 50) begin
          op = OP_PRG_FETCH;
        end else if (pick < 85) begin
          op = OP_CHR_FETCH;
        end else begin
          op = OP_NT_ACCESS;
        end
        // bias the reload value low so the counter fires often
        if (op == OP_REG_WRITE && reg_group_e'(addr[14:13]) == GRP_IRQ_LATCH &&
            !addr[0] && $urandom_range(0, 3) != 0) begin
          data = DataW'($urandom_range(0, 6));
        end
        send_access(op, addr, data);
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    bus_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 50) begin
          $display("%0t unexpected transaction: expected none, actual mapped %h irq %b",
                   $time, mapped_address_o, irq_pulse_o);
        end
      end else begin
        want = expected_results.pop_front();
        if (mapped_address_o !== want.mapped_address) begin
          mismatch_count++;
          if (mismatch_count <= 50) begin
            $display("%0t mapped_address expected %h actual %h",
                     $time, want.mapped_address, mapped_address_o);
          end
        end
        if (irq_pulse_o !== want.irq_pulse) begin
          mismatch_count++;
          if (mismatch_count <= 50) begin
            $display("%0t irq_pulse expected %b actual %b",
                     $time, want.irq_pulse, irq_pulse_o);
          end
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= 2000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_power_on_mapping();
    test_register_decode();
    test_scanline_irq();
    test_pattern_inversion();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
